// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/thc_pkg.sv =====
// ----------------------------------------------------------------------------
// thc_pkg
// types and constants of the thermal hot-spot centroid block
// ----------------------------------------------------------------------------
package thc_pkg;

	localparam int PIX_W  = 14;
	localparam int ROW_W  = 7;
	localparam int COL_W  = 8;
	localparam int SUM_W  = 22;
	localparam int CNT_W  = 15;
	localparam int STEP_W = $clog2(SUM_W);

	localparam int FRAME_ROWS = 120;
	localparam int FRAME_COLS = 160;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic [ROW_W-1:0] pixel_row;
		logic [COL_W-1:0] pixel_col;
		logic             frame_end;
	} in_word_t;

	typedef struct packed {
		logic             found;
		logic [COL_W-1:0] center_x;
		logic [ROW_W-1:0] center_y;
		logic [PIX_W-1:0] peak_value;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic step;
		logic deliver;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_sts_t;

endpackage

// ===== sv/thermal_hotspot_centroid_top.sv =====
// ----------------------------------------------------------------------------
// thermal_hotspot_centroid_top
// thresholded hot-pixel centroid and peak, one result per frame
// ----------------------------------------------------------------------------
// usage
//   input channel: one pixel word per accepted cycle (in_valid high, in_stall
//   low), raster order, frame_end set on the last pixel of a frame.
//   ordinary pixel words are taken every cycle; a frame_end word is taken
//   only while the divider is free, so in_stall rises only on a frame_end
//   word that arrives while the previous frame is still being divided or
//   its result is still waiting to enter the output register.
//   at frame end the sums and count are handed to two bit-serial dividers
//   sharing the count as divisor (one quotient bit per cycle); the result
//   is then written into the output register once that is free, which
//   raises out_valid with the result word.
//   the next frame accumulates meanwhile; frames of 24 words or more run
//   at one pixel per cycle while out_stall does not hold back a result.
//   output channel: result held in a register while out_stall is high; the
//   input side keeps accepting ordinary pixel words during that time.
//   cfg_we writes the threshold at once; write it only while idle.
//   reset clears threshold, accumulators and the output valid.
// ----------------------------------------------------------------------------
module thermal_hotspot_centroid_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [thc_pkg::PIX_W-1:0] cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  thc_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output thc_pkg::out_word_t out_word
);
	import thc_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    end_ready;
	logic    in_accept;
	logic    start;

	assign in_stall  = in_word.frame_end && !end_ready;
	assign in_accept = in_valid && !in_stall;
	assign start     = in_accept && in_word.frame_end;

	thc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sts       (sts),
		.cmd       (cmd),
		.end_ready (end_ready)
	);

	thc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_accept (in_accept),
		.in_word   (in_word),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

// ===== sv/thc_ctrl.sv =====
// ----------------------------------------------------------------------------
// thc_ctrl
// sequencer for the frame-end division and result hand-off
// ----------------------------------------------------------------------------
module thc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  thc_pkg::dp_sts_t sts,
	output thc_pkg::dp_cmd_t cmd,
	output logic            end_ready
);
	import thc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_DELIVER
	} state_t;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DIVIDE;
						step_q  <= '0;
					end
				end
				ST_DIVIDE: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_DELIVER;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DELIVER: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd.load    = start && (state_q == ST_IDLE);
		cmd.step    = (state_q == ST_DIVIDE);
		cmd.deliver = (state_q == ST_DELIVER) && !sts.out_busy;
		end_ready   = (state_q == ST_IDLE);
	end

endmodule

// ===== sv/thc_dp.sv =====
// ----------------------------------------------------------------------------
// thc_dp
// accumulators, shared-divisor bit-serial dividers and output register
// ----------------------------------------------------------------------------
module thc_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [thc_pkg::PIX_W-1:0] cfg_data,
	input  logic              in_accept,
	input  thc_pkg::in_word_t in_word,
	input  thc_pkg::dp_cmd_t  cmd,
	output thc_pkg::dp_sts_t  sts,
	output logic              out_valid,
	input  logic              out_stall,
	output thc_pkg::out_word_t out_word
);
	import thc_pkg::*;

	logic [PIX_W-1:0] thr_q;
	logic [SUM_W-1:0] col_sum_q;
	logic [SUM_W-1:0] row_sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PIX_W-1:0] peak_q;

	logic [SUM_W-1:0] col_sum_nxt;
	logic [SUM_W-1:0] row_sum_nxt;
	logic [CNT_W-1:0] cnt_nxt;
	logic [PIX_W-1:0] peak_nxt;
	logic [SUM_W:0]   col_add;
	logic [SUM_W:0]   row_add;
	logic             in_frame;
	logic             hot;
	logic             add_en;

	logic [SUM_W-1:0] col_quo_q;
	logic [SUM_W-1:0] row_quo_q;
	logic [CNT_W-1:0] col_rem_q;
	logic [CNT_W-1:0] row_rem_q;
	logic [CNT_W-1:0] div_q;
	logic [PIX_W-1:0] peak_hold_q;
	logic [CNT_W:0]   col_trial;
	logic [CNT_W:0]   row_trial;
	logic [CNT_W:0]   col_diff;
	logic [CNT_W:0]   row_diff;
	logic             col_bit;
	logic             row_bit;
	logic             found;

	logic             out_valid_q;
	out_word_t        out_word_q;

	always_comb begin
		in_frame = ({4'b0, in_word.pixel_row} < 11'(FRAME_ROWS)) &&
			({3'b0, in_word.pixel_col} < 11'(FRAME_COLS));
		hot    = in_frame && (in_word.pixel_value > thr_q);
		add_en = hot && (cnt_q != '1);
		col_add = {1'b0, col_sum_q} + (SUM_W+1)'(in_word.pixel_col);
		row_add = {1'b0, row_sum_q} + (SUM_W+1)'(in_word.pixel_row);
		col_sum_nxt = col_sum_q;
		row_sum_nxt = row_sum_q;
		cnt_nxt     = cnt_q;
		peak_nxt    = peak_q;
		if (add_en) begin
			col_sum_nxt = col_add[SUM_W] ? '1 : col_add[SUM_W-1:0];
			row_sum_nxt = row_add[SUM_W] ? '1 : row_add[SUM_W-1:0];
			cnt_nxt     = cnt_q + 1'b1;
		end
		if (hot && (in_word.pixel_value > peak_q)) begin
			peak_nxt = in_word.pixel_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= '0;
			col_sum_q <= '0;
			row_sum_q <= '0;
			cnt_q     <= '0;
			peak_q    <= '0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_data;
			end
			if (in_accept) begin
				if (in_word.frame_end) begin
					col_sum_q <= '0;
					row_sum_q <= '0;
					cnt_q     <= '0;
					peak_q    <= '0;
				end else begin
					col_sum_q <= col_sum_nxt;
					row_sum_q <= row_sum_nxt;
					cnt_q     <= cnt_nxt;
					peak_q    <= peak_nxt;
				end
			end
		end
	end

	// restoring division, one quotient bit per lane per cycle
	always_comb begin
		col_trial = {col_rem_q, col_quo_q[SUM_W-1]};
		row_trial = {row_rem_q, row_quo_q[SUM_W-1]};
		col_diff  = col_trial - {1'b0, div_q};
		row_diff  = row_trial - {1'b0, div_q};
		col_bit   = (col_trial >= {1'b0, div_q});
		row_bit   = (row_trial >= {1'b0, div_q});
		found     = (div_q != '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_quo_q   <= col_sum_nxt;
			row_quo_q   <= row_sum_nxt;
			col_rem_q   <= '0;
			row_rem_q   <= '0;
			div_q       <= cnt_nxt;
			peak_hold_q <= peak_nxt;
		end else if (cmd.step) begin
			col_quo_q <= {col_quo_q[SUM_W-2:0], col_bit};
			row_quo_q <= {row_quo_q[SUM_W-2:0], row_bit};
			col_rem_q <= col_bit ? col_diff[CNT_W-1:0] : col_trial[CNT_W-1:0];
			row_rem_q <= row_bit ? row_diff[CNT_W-1:0] : row_trial[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.deliver) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deliver) begin
			out_word_q.found      <= found;
			out_word_q.center_x   <= found ? col_quo_q[COL_W-1:0] : '0;
			out_word_q.center_y   <= found ? row_quo_q[ROW_W-1:0] : '0;
			out_word_q.peak_value <= found ? peak_hold_q : '0;
		end
	end

	assign sts.out_busy = out_valid_q && out_stall;
	assign out_valid    = out_valid_q;
	assign out_word     = out_word_q;

endmodule

// ===== sv/thc_checker.sv =====
// ----------------------------------------------------------------------------
// thc_checker
// port-level checks of the centroid block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module thc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input thc_pkg::in_word_t  in_word,
	input logic               out_valid,
	input logic               out_stall,
	input thc_pkg::out_word_t out_word
);
	import thc_pkg::*;

	`ASSERT_NEXT(a_out_hold_valid, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_out_hold_word, out_valid && out_stall, $stable(out_word))
	`ASSERT_IMPLIES(a_none_zero, out_valid && !out_word.found,
		(out_word.center_x == '0) && (out_word.center_y == '0) && (out_word.peak_value == '0))
	`ASSERT_IMPLIES(a_found_peak, out_valid && out_word.found, out_word.peak_value != '0)
	`ASSERT_IMPLIES(a_stall_on_end, in_valid && in_stall, in_word.frame_end)

endmodule

bind thermal_hotspot_centroid_top thc_checker u_thc_checker (.*);
